/* rtl/core/dhel_pkg.sv */
// Package for the directional hysteresis edge link unit.
// Holds frame limits, derived widths, codes, command/status structs and helpers.
// No dependencies.
package dhel_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int SLOTS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int UW_W       = $clog2(MAX_WIDTH + 1);
  localparam int UH_W       = $clog2(MAX_HEIGHT + 1);
  localparam int QENT_W     = ROW_W + COL_W;

  localparam int MAG_W = 8;
  localparam int DIR_W = 2;
  localparam int THR_W = 8;
  localparam int DIM_W = 9;

  // Operation codes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LOW    = 2'd0;
  localparam logic [1:0] REG_HIGH   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // Direction codes.
  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_135 = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] low_threshold;
    logic [THR_W-1:0] high_threshold;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_POP,
    ST_POP_WAIT,
    ST_DIR_WAIT,
    ST_NB,
    ST_NB_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic out_load;
    logic sweep_start;
    logic sweep_clr;
    logic sweep_rd;
    logic sweep_wr;
    logic pop;
    logic cur_load;
    logic dir_load;
    logic nb_issue;
    logic nb_wr;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic sweep_last;
    logic queue_empty;
    logic in_frame;
    logic k_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [1:0] dc;
    logic signed [1:0] dr;
  } step_t;

  // Neighbor offset for a direction code and neighbor number.
  function automatic step_t dir_step(input logic [1:0] code, input logic k);
    step_t s;
    case (code)
      DIR_0: begin
        s.dc = 2'sd0;
        s.dr = k ? 2'sd1 : -2'sd1;
      end
      DIR_45: begin
        s.dc = k ? 2'sd1 : -2'sd1;
        s.dr = k ? -2'sd1 : 2'sd1;
      end
      DIR_90: begin
        s.dc = k ? 2'sd1 : -2'sd1;
        s.dr = 2'sd0;
      end
      default: begin
        s.dc = k ? 2'sd1 : -2'sd1;
        s.dr = k ? 2'sd1 : -2'sd1;
      end
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/dhel_in_if.sv */
// Input channel of the edge link unit: valid/ready plus one pixel or read word.
// Depends on dhel_pkg.
interface dhel_in_if
  import dhel_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [MAG_W-1:0] magnitude;
  logic [DIR_W-1:0] direction;

  modport source (output valid, operation, magnitude, direction, input ready);
  modport sink (input valid, operation, magnitude, direction, output ready);
endinterface

/* rtl/core/dhel_out_if.sv */
// Output channel of the edge link unit: valid/ready plus one edge bit word.
// No dependencies.
interface dhel_out_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic last_pixel;

  modport source (output valid, edge_res, last_pixel, input ready);
  modport sink (input valid, edge_res, last_pixel, output ready);
endinterface

/* rtl/core/directional_hysteresis_edge_link_unit.sv */
// Hysteresis edge linking over one frame. Loads are accepted back to back;
// a read passes through the edge map read register and the output register
// to its result word, held back while the output is stalled. The load that
// completes a frame starts a seed pass over all MAX_WIDTH*MAX_HEIGHT slots
// of the edge map, then links each queued edge pixel: pop it, load its
// position and direction, and read each of its two neighbors in the frame,
// marking it when it links. After reset a clearing pass over every slot zeroes
// the edge map before the first word is accepted. Depends on dhel_pkg and the
// channel interfaces, and instantiates dhel_cfg, dhel_ctrl and dhel_dp.
module directional_hysteresis_edge_link_unit
  import dhel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dhel_in_if.sink     in_ch,
  dhel_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  dhel_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dhel_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .in_magnitude (in_ch.magnitude),
    .in_direction (in_ch.direction),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_edge     (out_ch.edge_res),
    .out_last     (out_ch.last_pixel)
  );

endmodule

/* rtl/core/dhel_cfg.sv */
// APB configuration registers of the edge link unit.
// Depends on dhel_pkg.
module dhel_cfg
  import dhel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= THR_W'(50);
      cfg.high_threshold <= THR_W'(150);
      cfg.frame_width    <= DIM_W'(256);
      cfg.frame_height   <= DIM_W'(256);
    end else if (wr_en) begin
      case (idx)
        REG_LOW:    cfg.low_threshold  <= pwdata[THR_W-1:0];
        REG_HIGH:   cfg.high_threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:  cfg.frame_width    <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg.frame_height   <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_LOW:    prdata = 32'(cfg.low_threshold);
      REG_HIGH:   prdata = 32'(cfg.high_threshold);
      REG_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_HEIGHT: prdata = 32'(cfg.frame_height);
      default:    prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/dhel_ctrl.sv */
// Controller of the edge link unit: sequences load, read, clear, seed and link.
// Depends on dhel_pkg.
module dhel_ctrl
  import dhel_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (sts.sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_READ) begin
            state_next = ST_RD_WAIT;
          end else if (sts.load_last) begin
            state_next = ST_SEED_RD;
          end
        end
      end
      ST_RD_WAIT:  if (sts.out_free) state_next = ST_IDLE;
      ST_SEED_RD:  state_next = ST_SEED_WR;
      ST_SEED_WR:  state_next = sts.sweep_last ? ST_POP : ST_SEED_RD;
      ST_POP:      state_next = sts.queue_empty ? ST_IDLE : ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_DIR_WAIT;
      ST_DIR_WAIT: state_next = ST_NB;
      ST_NB: begin
        if (sts.in_frame) begin
          state_next = ST_NB_WAIT;
        end else if (sts.k_last) begin
          state_next = ST_POP;
        end
      end
      ST_NB_WAIT:  state_next = sts.k_last ? ST_POP : ST_NB;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR:    cmd.sweep_clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_READ) begin
            cmd.rd_issue = 1'b1;
          end else begin
            cmd.load        = 1'b1;
            cmd.sweep_start = sts.load_last;
          end
        end
      end
      ST_RD_WAIT:  cmd.out_load = sts.out_free;
      ST_SEED_RD:  cmd.sweep_rd = 1'b1;
      ST_SEED_WR:  cmd.sweep_wr = 1'b1;
      ST_POP:      cmd.pop = !sts.queue_empty;
      ST_POP_WAIT: cmd.cur_load = 1'b1;
      ST_DIR_WAIT: cmd.dir_load = 1'b1;
      ST_NB: begin
        cmd.nb_issue = sts.in_frame;
        cmd.k_inc    = !sts.in_frame && !sts.k_last;
      end
      ST_NB_WAIT: begin
        cmd.nb_wr = 1'b1;
        cmd.k_inc = !sts.k_last;
      end
      default:     ;
    endcase
  end

endmodule

/* rtl/core/dhel_dp.sv */
// Datapath of the edge link unit: pixel stores, edge map, link queue, counters.
// Depends on dhel_pkg; driven by dhel_ctrl through cmd_t and sts_t.
module dhel_dp
  import dhel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [MAG_W-1:0] in_magnitude,
  input  logic [DIR_W-1:0] in_direction,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_edge,
  output logic             out_last
);

  logic [MAG_W-1:0]  mag_mem  [SLOTS];
  logic [DIR_W-1:0]  dir_mem  [SLOTS];
  logic              edge_mem [SLOTS];
  logic [QENT_W-1:0] q_mem    [SLOTS];

  logic [UW_W-1:0]   uw;
  logic [UH_W-1:0]   uh;
  logic [CNT_W-1:0]  total;

  logic [CNT_W-1:0]  load_pos, rd_pos;
  logic [CNT_W-1:0]  lp_eff, lp_inc, rp_eff, rp_inc;

  logic [ADDR_W-1:0] swp_i;
  logic [ROW_W-1:0]  swp_row;
  logic [COL_W-1:0]  swp_col;
  logic              swp_in_use, seed;

  logic [CNT_W-1:0]  head, tail;
  logic [QENT_W-1:0] q_q;
  logic [ROW_W-1:0]  cur_row, nb_row, nr_u;
  logic [COL_W-1:0]  cur_col, nb_col, nc_u;
  logic [DIR_W-1:0]  cur_dir, dir_q;
  logic              k;
  step_t             stp;
  logic signed [COL_W+1:0] nc;
  logic signed [ROW_W+1:0] nr;
  logic [ADDR_W-1:0] n_addr, nb_addr, pix_addr;

  logic [MAG_W-1:0]  mag_q;
  logic              edge_q, rd_last_q, link_ok;

  logic              mag_ren, edge_ren, edge_wen, edge_wdata, push;
  logic [ADDR_W-1:0] mag_raddr, edge_raddr, edge_waddr;
  logic [QENT_W-1:0] push_data;

  // Frame size in use, clamped to the supported range.
  always_comb begin
    if (cfg.frame_width == '0) begin
      uw = UW_W'(1);
    end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
      uw = UW_W'(MAX_WIDTH);
    end else begin
      uw = UW_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      uh = UH_W'(1);
    end else if (int'(cfg.frame_height) > MAX_HEIGHT) begin
      uh = UH_W'(MAX_HEIGHT);
    end else begin
      uh = UH_W'(cfg.frame_height);
    end
  end

  assign total = CNT_W'(uw * uh);

  // Load and read positions restart when the frame shrank below them.
  assign lp_eff = (load_pos >= total) ? '0 : load_pos;
  assign lp_inc = lp_eff + CNT_W'(1);
  assign rp_eff = (rd_pos >= total) ? '0 : rd_pos;
  assign rp_inc = rp_eff + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      rd_pos   <= '0;
    end else begin
      if (cmd.load) begin
        load_pos <= (lp_inc == total) ? '0 : lp_inc;
      end
      if (cmd.sweep_start) begin
        rd_pos <= '0;
      end else if (cmd.rd_issue) begin
        rd_pos <= (rp_inc == total) ? '0 : rp_inc;
      end
    end
  end

  // Pixel stores are written by loads.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_mem[lp_eff[ADDR_W-1:0]] <= in_magnitude;
      dir_mem[lp_eff[ADDR_W-1:0]] <= in_direction;
    end
  end

  // Sweep over every slot: clearing pass after reset and seed pass per frame.
  assign swp_in_use = {1'b0, swp_i} < total;
  assign seed       = swp_in_use && (mag_q >= cfg.high_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      swp_i   <= '0;
      swp_row <= '0;
      swp_col <= '0;
    end else if (cmd.sweep_start) begin
      swp_i   <= '0;
      swp_row <= '0;
      swp_col <= '0;
    end else if (cmd.sweep_clr || cmd.sweep_wr) begin
      swp_i <= swp_i + ADDR_W'(1);
      if ({1'b0, swp_col} == UW_W'(uw - UW_W'(1))) begin
        swp_col <= '0;
        swp_row <= swp_row + ROW_W'(1);
      end else begin
        swp_col <= swp_col + COL_W'(1);
      end
    end
  end

  // Neighbor selection for the pixel being linked.
  assign stp    = dir_step(cur_dir, k);
  assign nc     = $signed({2'b00, cur_col}) + (COL_W+2)'(stp.dc);
  assign nr     = $signed({2'b00, cur_row}) + (ROW_W+2)'(stp.dr);
  assign nc_u   = nc[COL_W-1:0];
  assign nr_u   = nr[ROW_W-1:0];
  assign n_addr = ADDR_W'(nr_u * uw + (ROW_W+UW_W)'(nc_u));
  assign pix_addr = ADDR_W'(q_q[QENT_W-1:COL_W] * uw + (ROW_W+UW_W)'(q_q[COL_W-1:0]));
  assign link_ok = !edge_q && (mag_q >= cfg.low_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 1'b0;
    end else if (cmd.dir_load) begin
      k <= 1'b0;
    end else if (cmd.k_inc) begin
      k <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur_row <= q_q[QENT_W-1:COL_W];
      cur_col <= q_q[COL_W-1:0];
    end
    if (cmd.dir_load) begin
      cur_dir <= dir_q;
    end
    if (cmd.nb_issue) begin
      nb_addr <= n_addr;
      nb_row  <= nr_u;
      nb_col  <= nc_u;
    end
  end

  // Memory port selection.
  always_comb begin
    mag_ren    = cmd.sweep_rd || cmd.nb_issue;
    mag_raddr  = cmd.sweep_rd ? swp_i : n_addr;
    edge_ren   = cmd.rd_issue || cmd.nb_issue;
    edge_raddr = cmd.rd_issue ? rp_eff[ADDR_W-1:0] : n_addr;
    edge_wen   = cmd.sweep_clr || cmd.sweep_wr || (cmd.nb_wr && link_ok);
    edge_waddr = cmd.nb_wr ? nb_addr : swp_i;
    edge_wdata = cmd.nb_wr || (cmd.sweep_wr && seed);
    push       = (cmd.sweep_wr && seed) || (cmd.nb_wr && link_ok);
    push_data  = cmd.nb_wr ? {nb_row, nb_col} : {swp_row, swp_col};
  end

  always_ff @(posedge clk) begin
    if (mag_ren) begin
      mag_q <= mag_mem[mag_raddr];
    end
    if (cmd.cur_load) begin
      dir_q <= dir_mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_ren) begin
      edge_q <= edge_mem[edge_raddr];
    end
    if (edge_wen) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
  end

  // Link queue.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail[ADDR_W-1:0]] <= push_data;
    end
    if (cmd.pop) begin
      q_q <= q_mem[head[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.sweep_start) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push) begin
        tail <= tail + CNT_W'(1);
      end
      if (cmd.pop) begin
        head <= head + CNT_W'(1);
      end
    end
  end

  // Read results and the output register.
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_last_q <= (rp_eff == total - CNT_W'(1));
    end
    if (cmd.out_load) begin
      out_edge <= edge_q;
      out_last <= rd_last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.load_last   = (lp_inc == total);
    sts.sweep_last  = (swp_i == ADDR_W'(SLOTS - 1));
    sts.queue_empty = (head == tail);
    sts.in_frame    = (nc >= 0) && (int'(nc) < int'(uw)) &&
                      (nr >= 0) && (int'(nr) < int'(uh));
    sts.k_last      = k;
    sts.out_free    = !out_valid || out_ready;
  end

  // The queue is never read past what was written.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("link queue head passed tail");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (head != tail))
    else $error("pop from empty link queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_restart_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_start |=> (head == '0) && (tail == '0))
    else $error("queue not emptied at seed pass start");

endmodule

/* sim/dhel_checker.sv */
`timescale 1ns / 100ps
// Checker for the edge link unit: watches both channels and the register port,
// predicts every read word from its own copy of the frame, and counts mismatches.
// Depends on dhel_pkg, dhel_in_if and dhel_out_if.
module dhel_checker
  import dhel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dhel_in_if          in_ch,
  dhel_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          words_owed
);

  typedef struct packed {
    logic edge_bit;
    logic last_bit;
  } edge_word_t;

  // Shadow copy of the configuration and frame state.
  logic [THR_W-1:0] low_thr, high_thr;
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [MAG_W-1:0] mag_mem [SLOTS];
  logic [DIR_W-1:0] dir_mem [SLOTS];
  logic             edge_mem [SLOTS];
  int               trace_fifo [SLOTS];
  int               load_at, read_at;
  edge_word_t       owed_words [$];

  assign words_owed = owed_words.size();

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // Seed marking followed by breadth-first growth along each pixel's direction.
  function automatic void trace_edges();
    int w, h, total, head, tail, at, col, row, nc, nr, n;
    step_t s;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    head = 0;
    tail = 0;
    for (int i = 0; i < SLOTS; i++) edge_mem[i] = 1'b0;
    for (int i = 0; i < total; i++) begin
      if (mag_mem[i] >= high_thr) begin
        edge_mem[i] = 1'b1;
        trace_fifo[tail++] = i;
      end
    end
    while (head < tail) begin
      at = trace_fifo[head++];
      col = at % w;
      row = at / w;
      for (int k = 0; k < 2; k++) begin
        case (dir_mem[at])
          DIR_0:   begin s.dc = 2'sd0; s.dr = k ? 2'sd1 : -2'sd1; end
          DIR_45:  begin s.dc = k ? 2'sd1 : -2'sd1; s.dr = k ? -2'sd1 : 2'sd1; end
          DIR_90:  begin s.dc = k ? 2'sd1 : -2'sd1; s.dr = 2'sd0; end
          default: begin s.dc = k ? 2'sd1 : -2'sd1; s.dr = k ? 2'sd1 : -2'sd1; end
        endcase
        nc = col + int'(s.dc);
        nr = row + int'(s.dr);
        if (nc >= 0 && nr >= 0 && nc < w && nr < h) begin
          n = nr * w + nc;
          if (!edge_mem[n] && mag_mem[n] >= low_thr) begin
            edge_mem[n] = 1'b1;
            trace_fifo[tail++] = n;
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    int total;
    edge_word_t want, got;
    if (rst) begin
      low_thr = 8'd50;
      high_thr = 8'd150;
      width_reg = 9'd256;
      height_reg = 9'd256;
      load_at = 0;
      read_at = 0;
      for (int i = 0; i < SLOTS; i++) edge_mem[i] = 1'b0;
      owed_words.delete();
      mismatches = 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LOW:    low_thr = pwdata[THR_W-1:0];
          REG_HIGH:   high_thr = pwdata[THR_W-1:0];
          REG_WIDTH:  width_reg = pwdata[DIM_W-1:0];
          REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
          default:    ;
        endcase
      end
      total = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      // Accepted input word: load a pixel or predict a read word.
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_LOAD) begin
          if (load_at >= total) load_at = 0;
          mag_mem[load_at] = in_ch.magnitude;
          dir_mem[load_at] = in_ch.direction;
          load_at++;
          if (load_at == total) begin
            trace_edges();
            load_at = 0;
            read_at = 0;
          end
        end else begin
          if (read_at >= total) read_at = 0;
          want.edge_bit = edge_mem[read_at];
          want.last_bit = (read_at == total - 1);
          owed_words.push_back(want);
          read_at++;
          if (read_at == total) read_at = 0;
        end
      end
      // Accepted output word: compare with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        got.edge_bit = out_ch.edge_res;
        got.last_bit = out_ch.last_pixel;
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word edge=%0b last=%0b", $time,
                   got.edge_bit, got.last_bit);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          if (got.edge_bit !== want.edge_bit) begin
            $display("%0t: edge_res expected %0b actual %0b", $time,
                     want.edge_bit, got.edge_bit);
            mismatches++;
          end
          if (got.last_bit !== want.last_bit) begin
            $display("%0t: last_pixel expected %0b actual %0b", $time,
                     want.last_bit, got.last_bit);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

/* sim/directional_hysteresis_edge_link_unit_test.sv */
`timescale 1ns / 100ps
// Top of the edge link unit testbench: clock, reset, register writes, frame
// stimulus with random idling, watchdog and verdict. Depends on dhel_pkg, the
// channel interfaces, dhel_checker and the unit itself.
module directional_hysteresis_edge_link_unit_test;
  import dhel_pkg::*;

  localparam int STALL_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          mismatches, words_owed, idle_cycles, stall_left;
  bit          quiet;

  dhel_in_if  in_ch ();
  dhel_out_if out_ch ();

  directional_hysteresis_edge_link_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dhel_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .words_owed(words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall bursts, none once the quiet phase begins.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word and no register write.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [MAG_W-1:0] mag,
                           input logic [DIR_W-1:0] dir);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.magnitude <= mag;
    in_ch.direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_reads(input int count);
    for (int i = 0; i < count; i++) send_word(OP_READ, MAG_W'($urandom), DIR_W'($urandom));
  endtask

  // Loads count random pixels, with reads mixed in at the given percentage.
  task automatic send_pixels(input int count, input int read_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        send_word(OP_READ, MAG_W'($urandom), DIR_W'($urandom));
      end
      send_word(OP_LOAD, MAG_W'($urandom), DIR_W'($urandom));
    end
  endtask

  // Drain every owed word before a register write.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input int low, input int high, input int w, input int h);
    write_reg(REG_LOW, low);
    write_reg(REG_HIGH, high);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    stall_left = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.magnitude = '0;
    in_ch.direction = DIR_0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Reads before any linking see the cleared edge map.
    send_reads(3);
    wait_drained();

    // Zero width used as one, low threshold zero, high at its maximum.
    set_frame(0, 255, 0, 4);
    send_word(OP_LOAD, 8'd255, DIR_0);
    send_word(OP_LOAD, 8'd0, DIR_45);
    send_word(OP_LOAD, 8'd128, DIR_90);
    send_word(OP_LOAD, 8'd1, DIR_135);
    send_reads(6);
    wait_drained();

    // Oversized width clamps to the maximum; low threshold above high.
    set_frame(255, 0, 511, 1);
    send_word(OP_LOAD, 8'd0, DIR_90);
    send_word(OP_LOAD, 8'd255, DIR_135);
    send_pixels(254, 0);
    send_reads(258);
    wait_drained();

    // Random frame with reads mixed into the loads.
    set_frame(60, 200, 20, 15);
    send_pixels(300, 15);
    send_reads(300);
    wait_drained();

    // Part of a frame, then a shrink that restarts the load position.
    set_frame($urandom_range(0, 120), $urandom_range(100, 255), 16, 16);
    send_pixels(100, 10);
    wait_drained();
    write_reg(REG_WIDTH, 8);
    write_reg(REG_HEIGHT, 8);
    send_pixels(64, 10);
    send_reads(70);
    wait_drained();

    // Oversized height, no idling on either side.
    quiet = 1'b1;
    set_frame(40, 180, 1, 511);
    send_pixels(256, 5);
    send_reads(256);
    wait_drained();
    repeat (200) @(negedge clk);

    if (mismatches == 0 && words_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
